// ===== sv/bfpa_pkg.sv =====
`timescale 1ns / 1ps
package bfpa_pkg;

    localparam int POOL_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int MIN_POOL         = 64;
    localparam int CFG_W            = 13;
    localparam int OFF_W            = 12;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FREED   = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [OFF_W-1:0] request_bytes;
        logic [OFF_W-1:0] free_offset;
    } req_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] payload_offset;
    } rsp_item_t;

endpackage

// ===== sv/best_fit_pool_allocator.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | req_data (kind, request_bytes, free_offset)
// rsp     | out       | rsp_valid/rsp_stall | rsp_data (status, payload_offset)
// cfg     | in        | cfg_valid/cfg_ready | cfg_data (pool_bytes)
//
// Allocate: the walk reads one header per cycle from the single header RAM read port.
// One transaction is in work at a time; the result sits in an output register,
//   so the next transaction is taken while it waits.
// Reset and every pool_bytes write clear every header, then write the first one.
// A stalled result only holds the final step; the walk itself never waits.
module best_fit_pool_allocator #(
    parameter int POOL_BYTES   = bfpa_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = bfpa_pkg::HEADER_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  bfpa_pkg::req_item_t         req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output bfpa_pkg::rsp_item_t         rsp_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bfpa_pkg::CFG_W-1:0]  cfg_data
);
    import bfpa_pkg::*;

    localparam int AW = $clog2(POOL_BYTES);
    localparam int PW = AW + 1;
    localparam int XW = (AW + 2 > 16) ? AW + 2 : 16;
    localparam int RESET_POOL = (POOL_BYTES < 4096) ? POOL_BYTES : 4096;

    typedef struct packed {
        logic          valid;
        logic          alloc;
        logic [AW-1:0] size;
        logic [AW-1:0] prev;
        logic          has_prev;
    } hdr_t;

    localparam int HW = $bits(hdr_t);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_WALK    = 4'd2;
    localparam logic [3:0] S_SPLIT_A = 4'd3;
    localparam logic [3:0] S_SPLIT_B = 4'd4;
    localparam logic [3:0] S_F_CUR   = 4'd5;
    localparam logic [3:0] S_F_NXT   = 4'd6;
    localparam logic [3:0] S_F_PRV   = 4'd7;
    localparam logic [3:0] S_F_WA    = 4'd8;
    localparam logic [3:0] S_F_WB    = 4'd9;
    localparam logic [3:0] S_F_WC    = 4'd10;
    localparam logic [3:0] S_LINK_RD = 4'd11;
    localparam logic [3:0] S_LINK_WR = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;
    localparam logic [3:0] S_CLEAR   = 4'd14;

    localparam logic [XW-1:0] HB = XW'(HEADER_BYTES);

    logic [3:0]       state_reg, state_next;
    logic [PW-1:0]    pool_reg;
    logic [XW-1:0]    pool_x;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [AW-1:0]    best_reg, best_next;
    logic [PW-1:0]    best_size_reg, best_size_next;
    logic [AW-1:0]    best_prev_reg, best_prev_next;
    logic             best_hp_reg, best_hp_next;
    logic             found_reg, found_next;
    logic [OFF_W-1:0] rqb_reg, rqb_next;
    logic [AW-1:0]    c_size_reg, c_size_next;
    logic [AW-1:0]    c_prev_reg, c_prev_next;
    logic             c_hp_reg, c_hp_next;
    logic [AW-1:0]    nx_reg, nx_next;
    logic             nx_ok_reg, nx_ok_next;
    logic             n_free_reg, n_free_next;
    logic [AW-1:0]    n_size_reg, n_size_next;
    logic             p_free_reg, p_free_next;
    logic [AW-1:0]    p_size_reg, p_size_next;
    logic [AW-1:0]    p_prev_reg, p_prev_next;
    logic             p_hp_reg, p_hp_next;
    logic [XW-1:0]    link_t_reg, link_t_next;
    logic [AW-1:0]    owner_reg, owner_next;
    rsp_item_t        wrk_reg, wrk_next;
    rsp_item_t        res_reg, res_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    hdr_t          wr_hdr;
    logic [AW-1:0] rd_addr;
    hdr_t          rd_hdr;
    logic [HW-1:0] rd_bits;

    logic [CFG_W+1:0] cfg_x;
    logic [PW-1:0]    cfg_clamped;

    logic [XW-1:0] cur_x, size_x, nc_x, need_x, foff_x, fcur_x, req_x, merged_x;
    logic          hit;

    bfpa_ram #(
        .WIDTH (HW),
        .DEPTH (1 << AW)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_hdr),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_hdr    = hdr_t'(rd_bits);
    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = res_reg;
    assign pool_x    = XW'(pool_reg);

    // Saturate the written pool size into the supported range.
    always_comb
    begin
        cfg_x = (CFG_W + 2)'(cfg_data);
        if (cfg_x < (CFG_W + 2)'(MIN_POOL))
            cfg_clamped = PW'(MIN_POOL);
        else if (XW'(cfg_x) > XW'(POOL_BYTES))
            cfg_clamped = PW'(POOL_BYTES);
        else
            cfg_clamped = PW'(cfg_x);
    end

    // Walk arithmetic: candidate test and the address of the next header.
    assign cur_x  = XW'(cur_reg);
    assign size_x = XW'(rd_hdr.size);
    assign nc_x   = cur_x + HB + size_x;
    assign req_x  = XW'(rqb_reg);
    assign need_x = req_x + HB;
    assign hit    = rd_hdr.valid && !rd_hdr.alloc && (size_x > need_x)
                    && (size_x < XW'(best_size_reg));
    assign foff_x = XW'(req_data.free_offset);
    assign fcur_x = foff_x - HB;
    assign merged_x = p_free_reg
        ? XW'(p_size_reg) + HB + XW'(c_size_reg)
          + (n_free_reg ? HB + XW'(n_size_reg) : '0)
        : XW'(c_size_reg) + (n_free_reg ? HB + XW'(n_size_reg) : '0);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        best_size_next = best_size_reg;
        best_prev_next = best_prev_reg;
        best_hp_next   = best_hp_reg;
        found_next     = found_reg;
        rqb_next       = rqb_reg;
        c_size_next    = c_size_reg;
        c_prev_next    = c_prev_reg;
        c_hp_next      = c_hp_reg;
        nx_next        = nx_reg;
        nx_ok_next     = nx_ok_reg;
        n_free_next    = n_free_reg;
        n_size_next    = n_size_reg;
        p_free_next    = p_free_reg;
        p_size_next    = p_size_reg;
        p_prev_next    = p_prev_reg;
        p_hp_next      = p_hp_reg;
        link_t_next    = link_t_reg;
        owner_next     = owner_reg;
        wrk_next       = wrk_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_hdr         = '0;
        rd_addr        = cur_reg;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // Drop every header so stale and unwritten entries read as invalid.
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                // Lay down the single free block covering the pool.
                wr_en         = 1'b1;
                wr_addr       = '0;
                wr_hdr.valid  = 1'b1;
                wr_hdr.size   = AW'(pool_x - HB);
                state_next    = S_IDLE;
            end
            S_IDLE:
            begin
                rd_addr = '0;
                if (req_valid)
                begin
                    wrk_next.payload_offset = '0;
                    rqb_next = req_data.request_bytes;
                    if (req_data.kind == KIND_FREE)
                    begin
                        wrk_next.status = ST_FREED;
                        cur_next        = AW'(fcur_x);
                        rd_addr         = AW'(fcur_x);
                        if (foff_x < HB || fcur_x >= pool_x)
                            state_next = S_DONE;
                        else
                            state_next = S_F_CUR;
                    end
                    else if (req_data.request_bytes == '0)
                    begin
                        wrk_next.status = ST_REFUSED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cur_next       = '0;
                        found_next     = 1'b0;
                        best_size_next = pool_reg;
                        state_next     = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                // One header per cycle; the next address comes from this size.
                if (hit)
                begin
                    best_next      = cur_reg;
                    best_size_next = PW'(size_x);
                    best_prev_next = rd_hdr.prev;
                    best_hp_next   = rd_hdr.has_prev;
                    found_next     = 1'b1;
                end
                cur_next = AW'(nc_x);
                rd_addr  = AW'(nc_x);
                if (!rd_hdr.valid || nc_x >= pool_x)
                begin
                    if (found_reg || hit)
                    begin
                        wrk_next.status = ST_ALLOC;
                        wrk_next.payload_offset =
                            OFF_W'(XW'(hit ? cur_reg : best_reg) + HB);
                        state_next = S_SPLIT_A;
                    end
                    else
                    begin
                        wrk_next.status         = ST_NOFIT;
                        wrk_next.payload_offset = '0;
                        state_next              = S_DONE;
                    end
                end
            end
            S_SPLIT_A:
            begin
                wr_en           = 1'b1;
                wr_addr         = best_reg;
                wr_hdr.valid    = 1'b1;
                wr_hdr.alloc    = 1'b1;
                wr_hdr.size     = AW'(req_x);
                wr_hdr.prev     = best_prev_reg;
                wr_hdr.has_prev = best_hp_reg;
                state_next      = S_SPLIT_B;
            end
            S_SPLIT_B:
            begin
                // Free remainder after the granted block.
                wr_en           = 1'b1;
                wr_addr         = AW'(XW'(best_reg) + HB + req_x);
                wr_hdr.valid    = 1'b1;
                wr_hdr.size     = AW'(XW'(best_size_reg) - req_x - HB);
                wr_hdr.prev     = best_reg;
                wr_hdr.has_prev = 1'b1;
                owner_next      = wr_addr;
                link_t_next     = XW'(best_reg) + HB + XW'(best_size_reg);
                state_next      = S_LINK_RD;
            end
            S_F_CUR:
            begin
                if (!rd_hdr.valid || !rd_hdr.alloc)
                    state_next = S_DONE;
                else
                begin
                    c_size_next = rd_hdr.size;
                    c_prev_next = rd_hdr.prev;
                    c_hp_next   = rd_hdr.has_prev;
                    nx_next     = AW'(nc_x);
                    nx_ok_next  = (nc_x < pool_x);
                    rd_addr     = AW'(nc_x);
                    state_next  = S_F_NXT;
                end
            end
            S_F_NXT:
            begin
                n_free_next = nx_ok_reg && rd_hdr.valid && !rd_hdr.alloc;
                n_size_next = rd_hdr.size;
                rd_addr     = c_prev_reg;
                state_next  = S_F_PRV;
            end
            S_F_PRV:
            begin
                p_free_next = c_hp_reg && (XW'(c_prev_reg) < pool_x)
                              && rd_hdr.valid && !rd_hdr.alloc;
                p_size_next = rd_hdr.size;
                p_prev_next = rd_hdr.prev;
                p_hp_next   = rd_hdr.has_prev;
                state_next  = S_F_WA;
            end
            S_F_WA:
            begin
                // Write the surviving header with its merged size.
                wr_en        = 1'b1;
                wr_hdr.valid = 1'b1;
                wr_hdr.size  = AW'(merged_x);
                if (p_free_reg)
                begin
                    wr_addr         = c_prev_reg;
                    wr_hdr.prev     = p_prev_reg;
                    wr_hdr.has_prev = p_hp_reg;
                end
                else
                begin
                    wr_addr         = cur_reg;
                    wr_hdr.prev     = c_prev_reg;
                    wr_hdr.has_prev = c_hp_reg;
                end
                owner_next  = wr_addr;
                link_t_next = XW'(wr_addr) + HB + merged_x;
                if (p_free_reg)
                    state_next = S_F_WB;
                else if (n_free_reg)
                    state_next = S_F_WC;
                else
                    state_next = S_DONE;
            end
            S_F_WB:
            begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg;
                state_next = n_free_reg ? S_F_WC : S_LINK_RD;
            end
            S_F_WC:
            begin
                wr_en      = 1'b1;
                wr_addr    = nx_reg;
                state_next = S_LINK_RD;
            end
            S_LINK_RD:
            begin
                rd_addr    = AW'(link_t_reg);
                state_next = (link_t_reg < pool_x) ? S_LINK_WR : S_DONE;
            end
            S_LINK_WR:
            begin
                wr_en           = 1'b1;
                wr_addr         = AW'(link_t_reg);
                wr_hdr          = rd_hdr;
                wr_hdr.prev     = owner_reg;
                wr_hdr.has_prev = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free, then load the result.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    res_next       = wrk_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pool_reg      <= PW'(RESET_POOL);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                pool_reg  <= cfg_clamped;
                state_reg <= S_CLEAR;
                clr_reg   <= '0;
            end
            else
            begin
                state_reg <= state_next;
                clr_reg   <= clr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        best_reg      <= best_next;
        best_size_reg <= best_size_next;
        best_prev_reg <= best_prev_next;
        best_hp_reg   <= best_hp_next;
        found_reg     <= found_next;
        rqb_reg       <= rqb_next;
        c_size_reg    <= c_size_next;
        c_prev_reg    <= c_prev_next;
        c_hp_reg      <= c_hp_next;
        nx_reg        <= nx_next;
        nx_ok_reg     <= nx_ok_next;
        n_free_reg    <= n_free_next;
        n_size_reg    <= n_size_next;
        p_free_reg    <= p_free_next;
        p_size_reg    <= p_size_next;
        p_prev_reg    <= p_prev_next;
        p_hp_reg      <= p_hp_next;
        link_t_reg    <= link_t_next;
        owner_reg     <= owner_next;
        wrk_reg       <= wrk_next;
        res_reg       <= res_next;
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_WALK) |-> !wr_en)
        else $error("header write outside an update step");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second transaction taken while one is in work");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status != ST_ALLOC) |-> rsp_data.payload_offset == '0)
        else $error("offset set on a non-grant result");

    a_pool_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pool_reg >= PW'(MIN_POOL)) && (XW'(pool_reg) <= XW'(POOL_BYTES)))
        else $error("pool size out of range");

endmodule

// ===== sv/bfpa_ram.sv =====
`timescale 1ns / 1ps
module bfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
